[sv/wra_pkg.sv]
`default_nettype none

package wra_pkg;

  localparam int WINDOW_LEN = 32;
  localparam int SAMPLE_W   = 24;
  localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [CNT_W-1:0]           count_t;

  // One averaging job handed from the front end to the divider.
  typedef struct packed {
    sum_t   sum;
    count_t count;
    logic   full;
  } job_t;

endpackage

`default_nettype wire

[sv/wra_queue.sv]
`default_nettype none

module wra_queue
  import wra_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  output logic      valid,
  input  wire logic pop,
  output job_t      pop_job
);

  job_t                 entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_PTR_W:0]     count;

  assign full    = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign valid   = (count != '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && valid)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && valid)) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_PTR_W+1)'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !(pop && valid)) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !valid)
    else $error("queue shows data while empty");

endmodule

`default_nettype wire

[sv/wra_front.sv]
`default_nettype none

module wra_front
  import wra_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     sample_valid,
  output logic          sample_stall,
  input  wire sample_t  sample,
  output logic          push,
  output job_t          push_job,
  input  wire logic     queue_full
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic    state;
  sample_t ring [WINDOW_LEN];
  sample_t old_sample;
  sample_t new_sample;
  sum_t    running_sum;
  sum_t    running_sum_next;
  count_t  fill_count;
  count_t  fill_count_next;
  logic [SLOT_W-1:0] write_slot;
  logic    was_full;

  assign sample_stall = (state != ST_IDLE);
  assign was_full     = (fill_count == CNT_W'(WINDOW_LEN));

  // Oldest sample leaves the sum only once the window is full.
  always_comb begin
    running_sum_next = running_sum + SUM_W'(new_sample);
    if (was_full) begin
      running_sum_next = running_sum_next - SUM_W'(old_sample);
    end
    fill_count_next = was_full ? fill_count : fill_count + 1'b1;
  end

  assign push           = (state == ST_CALC) && !queue_full;
  assign push_job.sum   = running_sum_next;
  assign push_job.count = fill_count_next;
  assign push_job.full  = (fill_count_next == CNT_W'(WINDOW_LEN));

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      old_sample <= ring[write_slot];
      new_sample <= sample;
    end else if (push) begin
      ring[write_slot] <= new_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      running_sum <= '0;
      fill_count  <= '0;
      write_slot  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (push) begin
            state       <= ST_IDLE;
            running_sum <= running_sum_next;
            fill_count  <= fill_count_next;
            if (write_slot == SLOT_W'(WINDOW_LEN - 1)) begin
              write_slot <= '0;
            end else begin
              write_slot <= write_slot + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW_LEN))
    else $error("fill count beyond window length");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full)
    else $error("push into a full queue");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_job.count != '0))
    else $error("job with zero divisor");

endmodule

`default_nettype wire

[sv/wra_back.sv]
`default_nettype none

module wra_back
  import wra_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  output logic      pop,
  input  wire job_t job,
  output logic      result_valid,
  input  wire logic result_stall,
  output sample_t   average,
  output logic      window_full
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_HOLD = 2'd2;

  logic [1:0]        state;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W:0]    rem;
  logic [CNT_W:0]    trial;
  count_t            divisor;
  logic              negative;
  logic              full_flag;
  logic [STEP_W-1:0] step;
  logic              out_free;
  logic [SUM_W-1:0]  magnitude;
  logic [SUM_W-1:0]  signed_quo;

  assign pop       = (state == B_IDLE) && job_valid;
  assign magnitude = job.sum[SUM_W-1] ? SUM_W'(-job.sum) : SUM_W'(job.sum);
  assign trial     = {rem[CNT_W-1:0], quo[SUM_W-1]};
  assign out_free  = !result_valid || !result_stall;
  assign signed_quo = negative ? (~quo + 1'b1) : quo;

  // Restoring division: one quotient bit per cycle, MSB first.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        quo       <= magnitude;
        rem       <= '0;
        divisor   <= job.count;
        negative  <= job.sum[SUM_W-1];
        full_flag <= job.full;
      end
      B_DIV: begin
        if (trial >= {1'b0, divisor}) begin
          rem <= trial - {1'b0, divisor};
          quo <= {quo[SUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[SUM_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (state == B_HOLD && out_free) begin
      average     <= signed_quo[SAMPLE_W-1:0];
      window_full <= full_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == B_HOLD && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            state <= B_DIV;
            step  <= STEP_W'(SUM_W - 1);
          end
        end
        B_DIV: begin
          if (step == '0) begin
            state <= B_HOLD;
          end else begin
            step <= step - 1'b1;
          end
        end
        B_HOLD: begin
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == B_DIV))
    else $error("pop did not start a division");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == B_HOLD) |-> (rem < {1'b0, divisor}))
    else $error("remainder not below divisor");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (state == B_HOLD && !out_free) |=> (state == B_HOLD))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

[sv/windowed_running_average.sv]
`default_nettype none

// Boxcar moving-average filter over the last WINDOW_LEN signed Q16.8 samples.
//
// Input channel: sample with sample_valid / sample_stall. A transfer happens at
// a rising edge where sample_valid is high and sample_stall is low.
// Output channel: average and window_full with result_valid / result_stall,
// one result per input sample, in order.
//
// The front end takes a sample and reads the oldest ring entry in the same
// cycle, then updates the running sum; it takes a new sample only once its
// job is in the queue. The back end divides the sum by the fill count with
// a restoring divider that makes one quotient bit per cycle for a 29-bit sum
// and takes a new item only once the last result is loaded, which sets the
// sustained throughput.
//
// Reset (rst, synchronous) empties the window: the sum, fill count and write
// slot go to zero and both channels go idle. When the receiver holds
// result_stall, the result stays put, the divider finishes the next item and
// waits, and further samples collect in the two-entry queue before the input
// side stalls.
module windowed_running_average_core
  import wra_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    sample_valid,
  output logic         sample_stall,
  input  wire sample_t sample,
  output logic         result_valid,
  input  wire logic    result_stall,
  output sample_t      average,
  output logic         window_full
);

  logic push;
  job_t push_job;
  logic queue_full;
  logic job_valid;
  logic pop;
  job_t job;

  // Front end: ring of samples and running sum.
  wra_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .push         (push),
    .push_job     (push_job),
    .queue_full   (queue_full)
  );

  // Decouples the fast front end from the slow divider.
  wra_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .valid    (job_valid),
    .pop      (pop),
    .pop_job  (job)
  );

  // Back end: signed division by the fill count and the output register.
  wra_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .pop          (pop),
    .job          (job),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .average      (average),
    .window_full  (window_full)
  );

endmodule

`default_nettype wire
